// ===== hdl/double_precision_multiplier_defines.svh =====
// Assertion macros used by the port-level checker file.
`ifndef DOUBLE_PRECISION_MULTIPLIER_DEFINES_SVH
`define DOUBLE_PRECISION_MULTIPLIER_DEFINES_SVH

// Check a property outside of reset.
`define FPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FPM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fpm_pkg.sv =====
// Shared constants, types and helpers of the binary64 multiplier.
`default_nettype none
package fpm_pkg;
  localparam logic [10:0] EXP_INF     = 11'h7FF;
  localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic signed [12:0] EXP_BIAS_ADJ = 13'sd1022;

  // Control that travels with each item down the pipe.
  typedef struct packed {
    logic        valid;
    logic        sign;
    logic        spec;
    logic [63:0] spec_val;
  } ctl_t;

  // Leading zeros of a 52-bit fraction (fraction assumed nonzero).
  function automatic logic [5:0] lead_zeros(input logic [51:0] f);
    logic [5:0] n;
    logic       found;
    n = 6'd0;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && f[i]) begin
        n = 6'(51 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/fpm_unpack.sv =====
// Stages 1-2: classify operands, normalize subnormal significands.
`default_nettype none
module fpm_unpack import fpm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [63:0]        a,
  input  wire logic [63:0]        b,
  output ctl_t                    ctl,
  output logic [52:0]             ma,
  output logic [52:0]             mb,
  output logic signed [12:0]      be
);
  ctl_t        ctl1;
  logic [10:0] ea1, eb1;
  logic [51:0] fa1, fb1;
  logic [5:0]  lza1, lzb1;

  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        a_zero, b_zero, a_nan, b_nan, a_inf, b_inf, sgn;
  ctl_t        ctl1_next;
  logic signed [12:0] xa, xb;

  assign ea = a[62:52];
  assign eb = b[62:52];
  assign fa = a[51:0];
  assign fb = b[51:0];
  assign sgn = a[63] ^ b[63];
  assign a_zero = (ea == 11'd0) && (fa == 52'd0);
  assign b_zero = (eb == 11'd0) && (fb == 52'd0);
  assign a_nan = (ea == EXP_INF) && (fa != 52'd0);
  assign b_nan = (eb == EXP_INF) && (fb != 52'd0);
  assign a_inf = (ea == EXP_INF);
  assign b_inf = (eb == EXP_INF);

  always_comb begin
    ctl1_next.valid = in_valid;
    ctl1_next.sign = sgn;
    ctl1_next.spec = 1'b1;
    if (a_nan) begin
      ctl1_next.spec_val = a | QUIET_BIT;
    end else if (b_nan) begin
      ctl1_next.spec_val = b | QUIET_BIT;
    end else if (a_inf || b_inf) begin
      ctl1_next.spec_val = (a_zero || b_zero) ? DEFAULT_NAN : {sgn, EXP_INF, 52'd0};
    end else if (a_zero || b_zero) begin
      ctl1_next.spec_val = {sgn, 63'd0};
    end else begin
      ctl1_next.spec = 1'b0;
      ctl1_next.spec_val = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl1.valid <= ctl1_next.valid;
      ctl.valid <= ctl1.valid;
    end
    if (en) begin
      ctl1.sign <= ctl1_next.sign;
      ctl1.spec <= ctl1_next.spec;
      ctl1.spec_val <= ctl1_next.spec_val;
      ea1 <= ea;
      eb1 <= eb;
      fa1 <= fa;
      fb1 <= fb;
      lza1 <= lead_zeros(fa);
      lzb1 <= lead_zeros(fb);
      ctl.sign <= ctl1.sign;
      ctl.spec <= ctl1.spec;
      ctl.spec_val <= ctl1.spec_val;
      ma <= (ea1 == 11'd0) ? ({1'b0, fa1} << (lza1 + 6'd1)) : {1'b1, fa1};
      mb <= (eb1 == 11'd0) ? ({1'b0, fb1} << (lzb1 + 6'd1)) : {1'b1, fb1};
      be <= xa + xb - EXP_BIAS_ADJ;
    end
  end

  assign xa = (ea1 == 11'd0) ? (13'sd0 - $signed({7'd0, lza1})) : $signed({2'd0, ea1});
  assign xb = (eb1 == 11'd0) ? (13'sd0 - $signed({7'd0, lzb1})) : $signed({2'd0, eb1});
endmodule
`default_nettype wire

// ===== hdl/fpm_mult.sv =====
// Stages 3-4: 53x53 significand product from four registered partial products.
`default_nettype none
module fpm_mult import fpm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire ctl_t               ctl_in,
  input  wire logic [52:0]        ma,
  input  wire logic [52:0]        mb,
  input  wire logic signed [12:0] be_in,
  output ctl_t                    ctl,
  output logic [105:0]            prod,
  output logic signed [12:0]      be
);
  ctl_t ctl3;
  logic signed [12:0] be3;
  logic [51:0] hh;
  logic [52:0] hl, lh;
  logic [53:0] ll;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl3.valid <= ctl_in.valid;
      ctl.valid <= ctl3.valid;
    end
    if (en) begin
      ctl3.sign <= ctl_in.sign;
      ctl3.spec <= ctl_in.spec;
      ctl3.spec_val <= ctl_in.spec_val;
      be3 <= be_in;
      hh <= ma[52:27] * mb[52:27];
      hl <= ma[52:27] * mb[26:0];
      lh <= ma[26:0] * mb[52:27];
      ll <= ma[26:0] * mb[26:0];
      ctl.sign <= ctl3.sign;
      ctl.spec <= ctl3.spec;
      ctl.spec_val <= ctl3.spec_val;
      be <= be3;
      prod <= {hh, 54'd0} + {25'd0, ({1'b0, hl} + {1'b0, lh}), 27'd0} + {52'd0, ll};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/fpm_round.sv =====
// Stages 5-6: normalize, denormalize on underflow, round to nearest even, pack.
`default_nettype none
module fpm_round import fpm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire ctl_t               ctl_in,
  input  wire logic [105:0]       prod,
  input  wire logic signed [12:0] be_in,
  output logic                    out_valid,
  output logic [63:0]             result
);
  ctl_t        ctl5;
  logic [63:0] sig5;
  logic [10:0] be5;
  logic        ovf5;

  logic [63:0] sig0, sig1, sig2;
  logic signed [12:0] be1, sh;
  logic [63:0] lost_mask;

  always_comb begin
    sig0 = {prod[105:43], prod[42] | (|prod[41:0])};
    if (!sig0[63]) begin
      sig1 = sig0 << 1;
      be1 = be_in - 13'sd1;
    end else begin
      sig1 = sig0;
      be1 = be_in;
    end
    sh = 13'sd1 - be1;
    lost_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << sh[5:0]);
    if (be1 > 13'sd0) begin
      sig2 = sig1;
    end else if (sh >= 13'sd64) begin
      sig2 = {63'd0, |sig1};
    end else begin
      sig2 = (sig1 >> sh[5:0]) | {63'd0, |(sig1 & lost_mask)};
    end
  end

  logic [52:0] mant;
  logic [10:0] rest;
  logic [53:0] mant_r;
  logic [63:0] res;
  logic [63:0] packed_val;

  always_comb begin
    mant = sig5[63:11];
    rest = sig5[10:0];
    if (rest > 11'h400 || (rest == 11'h400 && mant[0])) begin
      mant_r = {1'b0, mant} + 54'd1;
    end else begin
      mant_r = {1'b0, mant};
    end
    if (be5 == 11'd0) begin
      res = {10'd0, mant_r};
    end else begin
      res = {1'b0, be5 - 11'd1, 52'd0} + {10'd0, mant_r};
    end
    if (ctl5.spec) begin
      packed_val = ctl5.spec_val;
    end else if (ovf5 || res[63:52] >= {1'b0, EXP_INF}) begin
      packed_val = {ctl5.sign, EXP_INF, 52'd0};
    end else begin
      packed_val = {ctl5.sign, res[62:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5.valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      ctl5.valid <= ctl_in.valid;
      out_valid <= ctl5.valid;
    end
    if (en) begin
      ctl5.sign <= ctl_in.sign;
      ctl5.spec <= ctl_in.spec;
      ctl5.spec_val <= ctl_in.spec_val;
      sig5 <= sig2;
      ovf5 <= (be1 >= 13'sd2047);
      be5 <= (be1 > 13'sd0) ? be1[10:0] : 11'd0;
      result <= packed_val;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/double_precision_multiplier.sv =====
// Top level of the pipelined IEEE 754 binary64 multiplier.
// Usage:
//   Operand channel: drive operand_a, operand_b with operand_valid; a beat is
//   taken at a rising edge where operand_valid is high and operand_stall low.
//   Product channel: product is shown with product_valid; the receiver holds
//   product_stall high to keep the beat in place.
//   Throughput: one beat per cycle while product_stall does not hold the pipe;
//   six register stages (classify, normalize subnormals, partial products,
//   product sum, normalize/underflow, round) sit between the two channels.
//   The whole pipe advances together whenever the output register is empty
//   or its beat is being taken; only then is operand_stall low. A stall on
//   the product side therefore holds every stage, and nothing is lost or
//   repeated. An empty output register never holds the pipe, even while
//   product_stall is high.
//   Reset (rst, synchronous) clears every stage's valid bit; no state is
//   kept between beats, so nothing else needs clearing.
//   Rounding is nearest-even; NaNs come out quieted, infinity times zero
//   gives the default quiet NaN, subnormals are fully supported.
`default_nettype none
module double_precision_multiplier import fpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        operand_valid,
  output logic             operand_stall,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  output logic             product_valid,
  input  wire logic        product_stall,
  output logic [63:0]      product
);
  logic               adv;
  ctl_t               ctl2, ctl4;
  logic [52:0]        ma, mb;
  logic signed [12:0] be2, be4;
  logic [105:0]       prod;

  // Advance the pipe when the output register is free or being drained.
  assign adv = !product_valid || !product_stall;
  assign operand_stall = !adv;

  fpm_unpack u_unpack (
    .clk(clk), .rst(rst), .en(adv), .in_valid(operand_valid),
    .a(operand_a), .b(operand_b), .ctl(ctl2), .ma(ma), .mb(mb), .be(be2)
  );

  fpm_mult u_mult (
    .clk(clk), .rst(rst), .en(adv), .ctl_in(ctl2), .ma(ma), .mb(mb),
    .be_in(be2), .ctl(ctl4), .prod(prod), .be(be4)
  );

  fpm_round u_round (
    .clk(clk), .rst(rst), .en(adv), .ctl_in(ctl4), .prod(prod),
    .be_in(be4), .out_valid(product_valid), .result(product)
  );
endmodule
`default_nettype wire

// ===== hdl/fpm_checker.sv =====
// Port-level checker for the binary64 multiplier, bound to the top level.
`default_nettype none
`include "double_precision_multiplier_defines.svh"
module fpm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        operand_stall,
  input wire logic        product_valid,
  input wire logic        product_stall,
  input wire logic [63:0] product
);
  `FPM_ASSERT_ALWAYS(a_reset_empty, rst |=> !product_valid, "product_valid after reset")
  `FPM_ASSERT(a_backpressure, product_valid && product_stall |-> operand_stall, "stall not passed back")
  `FPM_ASSERT(a_hold_valid, product_valid && product_stall |=> product_valid, "product beat dropped")
  `FPM_ASSERT(a_hold_data, product_valid && product_stall |=> $stable(product), "stalled product changed")
endmodule

bind double_precision_multiplier fpm_checker u_fpm_checker (
  .clk(clk), .rst(rst), .operand_stall(operand_stall),
  .product_valid(product_valid), .product_stall(product_stall), .product(product)
);
`default_nettype wire

// ===== tb/sv/double_precision_multiplier_tb.sv =====
// Testbench for the binary64 multiplier: directed and random operand beats checked against a predictor.
`default_nettype none
module double_precision_multiplier_tb;
  import fpm_pkg::*;

  localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] HIDDEN    = 64'h0010_0000_0000_0000;
  localparam logic [63:0] SIGN_MSK  = 64'h8000_0000_0000_0000;
  localparam int          IDLE_LIMIT = 20000;
  localparam int          LATENCY    = 6;

  logic        clk;
  logic        rst;
  logic        operand_valid;
  logic        operand_stall;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  logic        product_valid;
  logic        product_stall;
  logic [63:0] product;

  logic [63:0] expected_products[$];
  int          mismatches;
  int          idle_cycles;
  bit          hold_long;     // receiver holds off while set
  bit          stall_free;    // receiver never stalls while set
  bit          all_sent;

  double_precision_multiplier i_dut (
    .clk(clk), .rst(rst),
    .operand_valid(operand_valid), .operand_stall(operand_stall),
    .operand_a(operand_a), .operand_b(operand_b),
    .product_valid(product_valid), .product_stall(product_stall),
    .product(product)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Split a finite nonzero value into significand (bit 52 set) and biased exponent.
  function automatic void split_value(input logic [63:0] v, output logic [63:0] sig,
                                      output int ex);
    ex  = int'(v[62:52]);
    sig = v & FRAC_MASK;
    if (ex == 0) begin
      ex = 1;
      while ((sig & HIDDEN) == 0) begin
        sig = sig << 1;
        ex--;
      end
    end else begin
      sig = sig | HIDDEN;
    end
  endfunction

  // Rounded binary64 product, nearest-even.
  function automatic logic [63:0] binary64_product(input logic [63:0] a,
                                                   input logic [63:0] b);
    logic [63:0]  sgn, ma, mb, sig, mant, res, lost;
    logic [127:0] full;
    logic [10:0]  rest;
    int           xa, xb, be, sh;
    bit           a_zero, b_zero;
    sgn = (a ^ b) & SIGN_MSK;
    a_zero = (a[62:0] == 63'd0);
    b_zero = (b[62:0] == 63'd0);
    // Propagate NaNs quieted, operand a first.
    if (a[62:52] == EXP_INF && a[51:0] != 0) return a | QUIET_BIT;
    if (b[62:52] == EXP_INF && b[51:0] != 0) return b | QUIET_BIT;
    if (a[62:52] == EXP_INF || b[62:52] == EXP_INF) begin
      if (a_zero || b_zero) return DEFAULT_NAN;
      return sgn | {1'b0, EXP_INF, 52'd0};
    end
    if (a_zero || b_zero) return sgn;
    split_value(a, ma, xa);
    split_value(b, mb, xb);
    full = (ma << 11) * (mb << 11);
    sig = full[127:64] | {63'd0, full[63:0] != 0};
    be = xa + xb - 1022;
    if (!sig[63]) begin
      sig = sig << 1;
      be--;
    end
    if (be >= 2047) return sgn | {1'b0, EXP_INF, 52'd0};
    if (be <= 0) begin
      sh = 1 - be;
      if (sh >= 64) sig = {63'd0, sig != 0};
      else begin
        lost = sig & ((64'd1 << sh) - 1);
        sig = (sig >> sh) | {63'd0, lost != 0};
      end
      be = 0;
    end
    mant = sig >> 11;
    rest = sig[10:0];
    if (rest > 11'h400 || (rest == 11'h400 && mant[0])) mant++;
    if (be == 0) res = mant;
    else res = (64'(be - 1) << 52) + mant;
    if (res[63:52] >= 12'(EXP_INF)) return sgn | {1'b0, EXP_INF, 52'd0};
    return sgn | res;
  endfunction

  // Receiver: stall on its own random pattern, hold off for a long stretch, or never stall.
  always @(posedge clk) begin
    if (rst) product_stall <= 1'b0;
    else if (hold_long) product_stall <= 1'b1;
    else if (stall_free) product_stall <= 1'b0;
    else product_stall <= ($urandom_range(0, 3) == 0);
  end

  // Check each product beat against the oldest expectation.
  always @(posedge clk) begin
    logic [63:0] exp_p;
    if (!rst && product_valid && !product_stall) begin
      if (expected_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected product beat %h", product);
      end else begin
        exp_p = expected_products.pop_front();
        if (product !== exp_p) begin
          mismatches++;
          if (mismatches <= 10)
            $display("product mismatch: expected %h actual %h", exp_p, product);
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if (rst || (operand_valid && !operand_stall) || (product_valid && !product_stall))
      idle_cycles <= 0;
    else if (!(all_sent && expected_products.size() == 0))
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  int burst_left;

  // Send one operand beat; hold until accepted. Gaps come between bursts.
  task automatic send_operands(input logic [63:0] a, input logic [63:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        operand_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    operand_valid <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    expected_products.push_back(binary64_product(a, b));
    @(posedge clk);
    while (operand_stall) @(posedge clk);
  endtask

  task automatic drain;
    operand_valid <= 1'b0;
    @(posedge clk);
    while (expected_products.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // Pick an operand from a class: normal, subnormal, zero, inf, NaN, raw.
  function automatic logic [63:0] pick_operand;
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(0, 9))
      0: v[62:52] = 11'd0;
      1: v[62:0] = 63'd0;
      2: v[62:0] = {EXP_INF, 52'd0};
      3: v[62:52] = EXP_INF;
      4: v[62:52] = 11'($urandom_range(1, 60));
      5: v[62:52] = 11'($urandom_range(1990, 2046));
      6: v[62:52] = 11'($urandom_range(990, 1060));
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_special_cases;
    logic [63:0] vals[12];
    vals = '{64'h0, SIGN_MSK, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
             64'h7FF0_0000_0000_0001, 64'hFFF8_0000_0000_0000, 64'h0000_0000_0000_0001,
             64'h000F_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
             64'hBFF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF};
    for (int i = 0; i < 12; i++) send_operands(vals[i], vals[(i * 5 + 3) % 12]);
    send_operands(64'h3FF0_0000_0000_0001, 64'h3CA0_0000_0000_0000); // exact product, no rounding
    send_operands(64'h0010_0000_0000_0000, 64'h3FE0_0000_0000_0000); // to subnormal
    send_operands(64'h0010_0000_0000_0001, 64'h3FEF_FFFF_FFFF_FFFF); // rounds down to the smallest normal
    send_operands(64'h7FE0_0000_0000_0000, 64'h4000_0000_0000_0000); // overflow
    send_operands(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001); // total underflow
    send_operands(64'h7FF4_0000_0000_0000, 64'h7FF0_0000_0000_0002); // both NaN
    drain();
  endtask

  task automatic test_random_operands;
    for (int i = 0; i < 560; i++) send_operands(pick_operand(), pick_operand());
    drain();
  endtask

  // Hold the receiver off long enough to fill the pipe and stall the input.
  task automatic test_backpressure;
    fork
      begin
        hold_long = 1'b1;
        repeat (60) @(posedge clk);
        hold_long = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_operands(pick_operand(), pick_operand());
    join
    drain();
  endtask

  task automatic test_full_rate;
    stall_free = 1'b1;
    burst_left = 40;
    for (int i = 0; i < 40; i++) send_operands(rand64(), rand64());
    drain();
    stall_free = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    operand_valid = 1'b0;
    operand_a = '0;
    operand_b = '0;
    hold_long = 1'b0;
    stall_free = 1'b0;
    all_sent = 1'b0;
    mismatches = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_backpressure();
    test_full_rate();
    test_random_operands();
    all_sent = 1'b1;
    repeat (LATENCY * 4) @(posedge clk);
    if (mismatches == 0 && expected_products.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/fpm_pkg.sv
hdl/fpm_unpack.sv
hdl/fpm_mult.sv
hdl/fpm_round.sv
hdl/double_precision_multiplier.sv
hdl/fpm_checker.sv
tb/sv/double_precision_multiplier_tb.sv
